FILE: hdl/clis_pkg.sv
// ----------------------------------------------------------------------------
// clis_pkg
// Shared types and constants for the closest layer index search block:
// opcodes, result status codes, register map and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package clis_pkg;

   // field widths
   localparam int HEIGHT_W   = 32;
   localparam int KEY_W      = HEIGHT_W + 1;
   localparam int DIST_W     = 32;
   localparam int TOL_W      = 31;
   localparam int INDEX_W    = 9;
   localparam int STATUS_W   = 3;
   localparam int OPCODE_W   = 2;

   // item opcodes
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OUT_TOL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

   // result index source
   localparam logic [1:0] IDX_NONE = 2'd0;
   localparam logic [1:0] IDX_LAST = 2'd1;
   localparam logic [1:0] IDX_BEST = 2'd2;

   // register map (register number is paddr[2])
   localparam int               CSR_ADDR_W    = 3;
   localparam int               CSR_DATA_W    = 32;
   localparam logic             REG_TOLERANCE = 1'b0;
   localparam logic [TOL_W-1:0] TOL_RESET     = 31'd66;

   // commands from controller to datapath
   typedef struct packed {
      logic                item_load;
      logic                count_clear;
      logic                entry_write;
      logic                rd_mid;
      logic                step;
      logic                rd_lo;
      logic                take_d1;
      logic                rd_lo_m1;
      logic                take_d0;
      logic                sel;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_status;
      logic [1:0]          rsp_idx_sel;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic lo_lt_hi;
      logic lo_at_end;
      logic lo_zero;
      logic out_tol;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

FILE: hdl/clis_datapath.sv
// ----------------------------------------------------------------------------
// clis_datapath
// Height table memory, entry count, search bounds, distance compare and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module clis_datapath #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  clis_pkg::dp_cmd_type          cmd,
   output clis_pkg::dp_sts_type                sts,
   input  wire  signed [clis_pkg::HEIGHT_W-1:0] req_height,
   input  wire  [clis_pkg::TOL_W-1:0]          tolerance,
   input  wire                                 rsp_stall,
   output logic                                rsp_valid,
   output logic signed [clis_pkg::INDEX_W-1:0] rsp_index,
   output logic [clis_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int HW = clis_pkg::HEIGHT_W;
   localparam int KW = clis_pkg::KEY_W;
   localparam int DW = clis_pkg::DIST_W;
   localparam int IW = clis_pkg::INDEX_W;

   logic [HW-1:0] mem [TABLE_DEPTH];

   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [CW-1:0]        best_idx_ff, best_idx_in;
   logic [DW-1:0]        best_dist_ff, best_dist_in;
   logic [DW-1:0]        dist0_ff, dist0_in;
   logic [HW-1:0]        z_ff, z_in;
   logic signed [KW-1:0] key_ff, key_in;
   logic [HW-1:0]        rdata_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]        rsp_index_ff, rsp_index_in;
   logic [clis_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [CW-1:0]        mid;
   logic [CW-1:0]        lo_m1;
   logic [CW-1:0]        last_idx;
   logic [AW-1:0]        raddr;
   logic                 rd_en;
   logic                 less;
   logic [KW-1:0]        diff;
   logic [KW-1:0]        diff_neg;
   logic [DW-1:0]        dist_cur;
   logic                 d0_better;
   logic [CW+IW-1:0]     last_wide;
   logic [CW+IW-1:0]     best_wide;

   // probe addresses
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_m1    = lo_ff - CW'(1);
   assign last_idx = count_ff - CW'(1);

   always_comb begin
      if (cmd.rd_lo) begin
         raddr = lo_ff[AW-1:0];
      end else if (cmd.rd_lo_m1) begin
         raddr = lo_m1[AW-1:0];
      end else begin
         raddr = mid[AW-1:0];
      end
   end

   assign rd_en = cmd.rd_mid | cmd.rd_lo | cmd.rd_lo_m1;

   // table memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.entry_write) begin
         mem[count_ff[AW-1:0]] <= req_height;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   // search compare and distance to the query height
   assign less      = $signed({rdata_ff[HW-1], rdata_ff}) < key_ff;
   assign diff      = {rdata_ff[HW-1], rdata_ff} - {z_ff[HW-1], z_ff};
   assign diff_neg  = ~diff + KW'(1);
   assign dist_cur  = diff[KW-1] ? diff_neg[DW-1:0] : diff[DW-1:0];
   assign d0_better = dist0_ff < best_dist_ff;

   // index extension to the result width
   assign last_wide = {IW'(0), last_idx};
   assign best_wide = {IW'(0), best_idx_ff};

   // next state
   always_comb begin
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      dist0_in      = dist0_ff;
      z_in          = z_ff;
      key_in        = key_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.count_clear) begin
         count_in = '0;
      end else if (cmd.entry_write) begin
         count_in = count_ff + CW'(1);
      end

      if (cmd.item_load) begin
         z_in   = req_height;
         key_in = $signed({req_height[HW-1], req_height} - {2'b00, tolerance});
         lo_in  = '0;
         hi_in  = count_ff;
      end else if (cmd.step) begin
         if (less) begin
            lo_in = mid + CW'(1);
         end else begin
            hi_in = mid;
         end
      end

      if (cmd.take_d1) begin
         best_idx_in  = lo_ff;
         best_dist_in = dist_cur;
      end else if (cmd.sel && d0_better) begin
         best_idx_in  = lo_m1;
         best_dist_in = dist0_ff;
      end

      if (cmd.take_d0) begin
         dist0_in = dist_cur;
      end

      if (cmd.rsp_load) begin
         rsp_status_in = cmd.rsp_status;
         case (cmd.rsp_idx_sel)
            clis_pkg::IDX_LAST: rsp_index_in = last_wide[IW-1:0];
            clis_pkg::IDX_BEST: rsp_index_in = best_wide[IW-1:0];
            default:            rsp_index_in = '1;
         endcase
      end
   end

   // result register holds until taken
   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_dist_ff  <= best_dist_in;
      dist0_ff      <= dist0_in;
      z_ff          <= z_in;
      key_ff        <= key_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   // status to the controller
   assign sts.count_zero = count_ff == '0;
   assign sts.count_full = count_ff == CW'(TABLE_DEPTH);
   assign sts.lo_lt_hi   = lo_ff < hi_ff;
   assign sts.lo_at_end  = lo_ff == count_ff;
   assign sts.lo_zero    = lo_ff == '0;
   assign sts.out_tol    = best_dist_ff > {1'b0, tolerance};
   assign sts.out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_index  = $signed(rsp_index_ff);
   assign rsp_status = rsp_status_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      lo_ff <= hi_ff)
      else $error("search bounds crossed");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      cmd.entry_write |-> count_ff < CW'(TABLE_DEPTH))
      else $error("append written to a full table");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

FILE: hdl/clis_ctrl.sv
// ----------------------------------------------------------------------------
// clis_ctrl
// Sequencer for clear, append and the binary search query: walks the probe
// loop, the neighbor compare and the tolerance check, and loads results.
// ----------------------------------------------------------------------------
`default_nettype none

module clis_ctrl (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  wire  [clis_pkg::OPCODE_W-1:0]       req_opcode,
   output logic                                req_stall,
   output clis_pkg::dp_cmd_type                cmd,
   input  wire  clis_pkg::dp_sts_type          sts
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ADDR  = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_POST  = 3'd3;
   localparam logic [2:0] S_D1    = 3'd4;
   localparam logic [2:0] S_D0    = 3'd5;
   localparam logic [2:0] S_SEL   = 3'd6;
   localparam logic [2:0] S_CHECK = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       accept;

   // new beat only when idle and the result register can take a value
   assign req_stall = !((state_ff == S_IDLE) && sts.out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  clis_pkg::OP_CLEAR: begin
                     cmd.count_clear = 1'b1;
                     cmd.rsp_load    = 1'b1;
                     cmd.rsp_status  = clis_pkg::ST_DONE;
                     cmd.rsp_idx_sel = clis_pkg::IDX_NONE;
                  end
                  clis_pkg::OP_APPEND: begin
                     cmd.rsp_load    = 1'b1;
                     cmd.rsp_idx_sel = clis_pkg::IDX_NONE;
                     if (sts.count_full) begin
                        cmd.rsp_status = clis_pkg::ST_FULL;
                     end else begin
                        cmd.entry_write = 1'b1;
                        cmd.rsp_status  = clis_pkg::ST_DONE;
                     end
                  end
                  clis_pkg::OP_QUERY: begin
                     if (sts.count_zero) begin
                        cmd.rsp_load    = 1'b1;
                        cmd.rsp_status  = clis_pkg::ST_EMPTY;
                        cmd.rsp_idx_sel = clis_pkg::IDX_NONE;
                     end else begin
                        cmd.item_load = 1'b1;
                        state_in      = S_ADDR;
                     end
                  end
                  default: begin
                     cmd.rsp_load    = 1'b1;
                     cmd.rsp_status  = clis_pkg::ST_DONE;
                     cmd.rsp_idx_sel = clis_pkg::IDX_NONE;
                  end
               endcase
            end
         end
         // one probe per pass: read mid, then narrow the bounds
         S_ADDR: begin
            if (sts.lo_lt_hi) begin
               cmd.rd_mid = 1'b1;
               state_in   = S_CMP;
            end else begin
               state_in = S_POST;
            end
         end
         S_CMP: begin
            cmd.step = 1'b1;
            state_in = S_ADDR;
         end
         // nothing at or above the key gives the last index
         S_POST: begin
            if (sts.lo_at_end) begin
               if (sts.out_free) begin
                  cmd.rsp_load    = 1'b1;
                  cmd.rsp_status  = clis_pkg::ST_FOUND;
                  cmd.rsp_idx_sel = clis_pkg::IDX_LAST;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.rd_lo = 1'b1;
               state_in  = S_D1;
            end
         end
         S_D1: begin
            cmd.take_d1 = 1'b1;
            if (sts.lo_zero) begin
               state_in = S_CHECK;
            end else begin
               cmd.rd_lo_m1 = 1'b1;
               state_in     = S_D0;
            end
         end
         S_D0: begin
            cmd.take_d0 = 1'b1;
            state_in    = S_SEL;
         end
         S_SEL: begin
            cmd.sel  = 1'b1;
            state_in = S_CHECK;
         end
         // tolerance check on the chosen entry
         S_CHECK: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               if (sts.out_tol) begin
                  cmd.rsp_status  = clis_pkg::ST_OUT_TOL;
                  cmd.rsp_idx_sel = clis_pkg::IDX_NONE;
               end else begin
                  cmd.rsp_status  = clis_pkg::ST_FOUND;
                  cmd.rsp_idx_sel = clis_pkg::IDX_BEST;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // checks
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_IDLE) || (state_ff == S_ADDR))
      else $error("accepted beat led to an unexpected state");

   a_query_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> $past(cmd.rd_mid))
      else $error("compare without a probe read");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> state_ff == S_IDLE)
      else $error("result loaded but sequence not finished");

endmodule

`default_nettype wire

FILE: hdl/closest_layer_index_search.sv
// ----------------------------------------------------------------------------
// closest_layer_index_search
// Keeps an ascending table of signed 16.16 layer heights and answers
// nearest-layer queries within a programmable tolerance.
// ----------------------------------------------------------------------------
// Clear and append beats are answered from the idle state. A query runs a
// lower-bound binary search over the table, one probe per pass through the
// address and compare states, set by the single registered read port of the
// height memory, followed by a neighbor compare and tolerance check. One beat
// is in work at a time; a finished result waits in an output register, and the
// next beat is taken as soon as that register is free or being drained. The
// tolerance register sits at byte address 0 and should only be written while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module closest_layer_index_search #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // input channel
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [clis_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire  signed [clis_pkg::HEIGHT_W-1:0]  req_height,
   // result channel
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [clis_pkg::INDEX_W-1:0]   rsp_index,
   output logic [clis_pkg::STATUS_W-1:0]         rsp_status,
   // register port
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire  [clis_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire  [clis_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [clis_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   logic [clis_pkg::TOL_W-1:0] tolerance_ff, tolerance_in;
   logic                       reg_hit;
   logic                       reg_write;
   clis_pkg::dp_cmd_type       cmd;
   clis_pkg::dp_sts_type       sts;

   // register decode
   assign reg_hit   = paddr[2] == clis_pkg::REG_TOLERANCE;
   assign reg_write = psel && penable && pwrite && reg_hit;
   assign pready    = 1'b1;

   assign tolerance_in = reg_write ? pwdata[clis_pkg::TOL_W-1:0] : tolerance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= clis_pkg::TOL_RESET;
      end else begin
         tolerance_ff <= tolerance_in;
      end
   end

   // read back
   assign prdata = reg_hit ? {1'b0, tolerance_ff} : '0;

   clis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   clis_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_height (req_height),
      .tolerance  (tolerance_ff),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_index  (rsp_index),
      .rsp_status (rsp_status)
   );

endmodule

`default_nettype wire

FILE: test/layer_match_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// layer_match_checker
// Watches the item, result and register ports of the closest layer index
// search block. Keeps a shadow of the height table and the tolerance,
// predicts the result of every accepted item beat and compares each result
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module layer_match_checker #(
   parameter int TABLE_DEPTH = 256
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   input  wire                                   req_stall,
   input  wire  [clis_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire  signed [clis_pkg::HEIGHT_W-1:0]  req_height,
   input  wire                                   rsp_valid,
   input  wire                                   rsp_stall,
   input  wire  signed [clis_pkg::INDEX_W-1:0]   rsp_index,
   input  wire  [clis_pkg::STATUS_W-1:0]         rsp_status,
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire                                   pready,
   input  wire  [clis_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire  [clis_pkg::CSR_DATA_W-1:0]       pwdata,
   output int                                    fail_count,
   output int                                    pending
);

   // heights widened so that key and distances never wrap
   localparam int WIDE_W = clis_pkg::HEIGHT_W + 2;

   typedef struct packed {
      logic signed [clis_pkg::INDEX_W-1:0] index;
      logic [clis_pkg::STATUS_W-1:0]       status;
   } layer_match_type;

   logic signed [clis_pkg::HEIGHT_W-1:0] height_tab [TABLE_DEPTH];
   int                                   entry_cnt;
   logic [clis_pkg::TOL_W-1:0]           tol_reg;
   layer_match_type                      layer_match_q [$];
   layer_match_type                      want;
   int                                   errs;

   initial begin
      fail_count = 0;
      pending    = 0;
      errs       = 0;
      entry_cnt  = 0;
      tol_reg    = clis_pkg::TOL_RESET;
   end

   function automatic logic signed [WIDE_W-1:0] span(input logic signed [WIDE_W-1:0] a,
                                                    input logic signed [WIDE_W-1:0] b);
      logic signed [WIDE_W-1:0] d;
      d = a - b;
      return (d < 0) ? -d : d;
   endfunction

   // apply one item beat to the shadow table and return its result
   function automatic layer_match_type resolve_item(
      input logic [clis_pkg::OPCODE_W-1:0]        op,
      input logic signed [clis_pkg::HEIGHT_W-1:0] h);
      layer_match_type          r;
      logic signed [WIDE_W-1:0] z;
      logic signed [WIDE_W-1:0] tol;
      logic signed [WIDE_W-1:0] key;
      int                       lo;
      int                       hi;
      int                       mid;
      int                       pick;
      r.index  = '1;
      r.status = clis_pkg::ST_DONE;
      z        = h;
      tol      = WIDE_W'(tol_reg);
      key      = z - tol;
      case (op)
         clis_pkg::OP_CLEAR: begin
            entry_cnt = 0;
         end
         clis_pkg::OP_APPEND: begin
            if (entry_cnt >= TABLE_DEPTH) begin
               r.status = clis_pkg::ST_FULL;
            end else begin
               height_tab[entry_cnt] = h;
               entry_cnt++;
            end
         end
         clis_pkg::OP_QUERY: begin
            if (entry_cnt == 0) begin
               r.status = clis_pkg::ST_EMPTY;
            end else begin
               // lower bound: first entry not below height minus tolerance
               lo = 0;
               hi = entry_cnt;
               while (lo < hi) begin
                  mid = lo + ((hi - lo) >> 1);
                  if (height_tab[mid] < key) lo = mid + 1;
                  else hi = mid;
               end
               if (lo >= entry_cnt) begin
                  // nothing qualifies: last index, no tolerance check
                  r.index  = clis_pkg::INDEX_W'(entry_cnt - 1);
                  r.status = clis_pkg::ST_FOUND;
               end else begin
                  // predecessor wins only when strictly nearer
                  pick = lo;
                  if (pick > 0 && span(height_tab[pick-1], z) < span(height_tab[pick], z))
                     pick--;
                  if (span(height_tab[pick], z) > tol) begin
                     r.status = clis_pkg::ST_OUT_TOL;
                  end else begin
                     r.index  = clis_pkg::INDEX_W'(pick);
                     r.status = clis_pkg::ST_FOUND;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         entry_cnt = 0;
         tol_reg   = clis_pkg::TOL_RESET;
         layer_match_q.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready && paddr[2] == clis_pkg::REG_TOLERANCE)
            tol_reg = pwdata[clis_pkg::TOL_W-1:0];
         // item beat: predict first, a same-edge result can only be older
         if (req_valid && !req_stall)
            layer_match_q.push_back(resolve_item(req_opcode, req_height));
         // result beat
         if (rsp_valid && !rsp_stall) begin
            if (layer_match_q.size() == 0) begin
               $error("result beat with nothing expected: index %0d status %0d",
                      rsp_index, rsp_status);
               errs++;
            end else begin
               want = layer_match_q.pop_front();
               if (rsp_index !== want.index) begin
                  $error("index mismatch: expected %0d actual %0d",
                         $signed(want.index), rsp_index);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d actual %0d",
                         want.status, rsp_status);
                  errs++;
               end
            end
         end
      end
      pending    <= layer_match_q.size();
      fail_count <= errs;
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the closest layer index search block: a directed
// pass over the edge heights and special cases, then phases of ascending
// appends with queries around stored heights, mixed with noise, under random
// idling on both channels. Checking is done by layer_match_checker.
// ----------------------------------------------------------------------------

module tb;

   localparam int TABLE_DEPTH = 256;
   localparam int RAND_ITEMS  = 720;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 40;
   localparam int LIMIT_NS    = 3_000_000;

   localparam logic [clis_pkg::OPCODE_W-1:0]        OP_SPARE = 2'd3;
   localparam logic signed [clis_pkg::HEIGHT_W-1:0] H_MIN    = 32'sh8000_0000;
   localparam logic signed [clis_pkg::HEIGHT_W-1:0] H_MAX    = 32'sh7fff_ffff;
   localparam logic [clis_pkg::TOL_W-1:0]           TOL_MAX  = '1;
   localparam logic [clis_pkg::CSR_ADDR_W-1:0]      TOL_ADDR =
      {clis_pkg::REG_TOLERANCE, 2'b00};

   logic                                 clock     = 1'b0;
   logic                                 reset     = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [clis_pkg::OPCODE_W-1:0]        req_opcode = clis_pkg::OP_CLEAR;
   logic signed [clis_pkg::HEIGHT_W-1:0] req_height = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [clis_pkg::INDEX_W-1:0]  rsp_index;
   logic [clis_pkg::STATUS_W-1:0]        rsp_status;
   logic                                 psel    = 1'b0;
   logic                                 penable = 1'b0;
   logic                                 pwrite  = 1'b0;
   logic [clis_pkg::CSR_ADDR_W-1:0]      paddr   = '0;
   logic [clis_pkg::CSR_DATA_W-1:0]      pwdata  = '0;
   logic [clis_pkg::CSR_DATA_W-1:0]      prdata;
   logic                                 pready;
   int                                   fail_count;
   int                                   pending;

   // stimulus-side view of the table, only used to aim queries
   logic signed [clis_pkg::HEIGHT_W-1:0] shadow [TABLE_DEPTH];
   int                                   shadow_n   = 0;
   int                                   item_total = 0;
   longint                               tol_now    = 66;
   bit                                   calm       = 1'b0;
   bit                                   hold_go    = 1'b0;

   closest_layer_index_search #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_height (req_height),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_index  (rsp_index),
      .rsp_status (rsp_status),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   layer_match_checker #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_height (req_height),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_index  (rsp_index),
      .rsp_status (rsp_status),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #(LIMIT_NS);
      $display("closest_layer_index_search verification failed");
      $finish;
   end

   // result side: random stall, calm stretch, one long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
         end else if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
         end
         rsp_stall <= (hold_left > 0) || (!calm && $urandom_range(99) < 32);
      end
   end

   function automatic logic signed [clis_pkg::HEIGHT_W-1:0] pin_height(input longint v);
      if (v > longint'(H_MAX)) return H_MAX;
      if (v < longint'(H_MIN)) return H_MIN;
      return v[clis_pkg::HEIGHT_W-1:0];
   endfunction

   function automatic longint rand_span(input longint reach);
      return longint'($urandom_range(32'(2 * reach))) - reach;
   endfunction

   // query height: mostly near a stored entry, sometimes anywhere
   function automatic logic signed [clis_pkg::HEIGHT_W-1:0] probe_height();
      longint reach;
      longint e;
      int     k;
      reach = (tol_now > 1048576) ? 1048576 : tol_now;
      if (shadow_n == 0 || $urandom_range(99) < 15) return $urandom;
      e = shadow[$urandom_range(shadow_n - 1)];
      k = $urandom_range(99);
      if (k < 8) return pin_height(e + tol_now);
      if (k < 16) return pin_height(e - tol_now);
      if (k < 22) return pin_height(e + tol_now + 1);
      return pin_height(e + rand_span(2 * reach + 2));
   endfunction

   // one item beat, with a random idle gap in front
   task automatic send_item(input logic [clis_pkg::OPCODE_W-1:0] op,
                            input logic signed [clis_pkg::HEIGHT_W-1:0] h);
      int gap;
      gap = 0;
      if (!calm)
         while ($urandom_range(99) < 32) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_height <= h;
      do @(posedge clock); while (req_stall);
      if (op == clis_pkg::OP_CLEAR) begin
         shadow_n = 0;
      end else if (op == clis_pkg::OP_APPEND && shadow_n < TABLE_DEPTH) begin
         shadow[shadow_n] = h;
         shadow_n++;
      end
      if (op != OP_SPARE) item_total++;
   endtask

   // stop offering and wait until every expected result beat is in
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [clis_pkg::CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= TOL_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      tol_now = longint'(value[clis_pkg::TOL_W-1:0]);
   endtask

   // one phase: optional clear, mostly ascending appends, then mostly queries
   task automatic run_phase(input bit big);
      int     n_app;
      int     n_probe;
      int     i;
      int     k;
      bit     shuffled;
      longint h;
      longint step_max;
      if ($urandom_range(99) < 85) send_item(clis_pkg::OP_CLEAR, $urandom);
      n_app    = big ? TABLE_DEPTH + $urandom_range(5, 2) : $urandom_range(24, 1);
      shuffled = ($urandom_range(99) < 10);
      step_max = (tol_now > 262144) ? 1048576 : 4 * tol_now + 4;
      case ($urandom_range(3))
         0: h = longint'(H_MIN) + $urandom_range(1000);
         1: h = longint'($signed($urandom));
         default: h = rand_span(1 << 20);
      endcase
      for (i = 0; i < n_app; i++) begin
         if (shuffled) h = longint'($signed($urandom));
         else h = pin_height(h + $urandom_range(32'(step_max)));
         send_item(clis_pkg::OP_APPEND, pin_height(h));
         if ($urandom_range(99) < 20) send_item(clis_pkg::OP_QUERY, probe_height());
      end
      n_probe = $urandom_range(30, 8);
      for (i = 0; i < n_probe; i++) begin
         k = $urandom_range(99);
         if (k < 3) send_item(OP_SPARE, $urandom);
         else if (k < 6) send_item(clis_pkg::OP_APPEND, $urandom);
         else if (k < 7) send_item(clis_pkg::OP_CLEAR, $urandom);
         else send_item(clis_pkg::OP_QUERY, probe_height());
      end
   endtask

   // main sequence
   initial begin
      int                         phase_no;
      int                         base_total;
      logic [clis_pkg::TOL_W-1:0] tol_pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset tolerance, empty table, edge heights
      send_item(clis_pkg::OP_QUERY, 32'sd0);
      send_item(OP_SPARE, H_MAX);
      send_item(clis_pkg::OP_APPEND, H_MIN);
      send_item(clis_pkg::OP_APPEND, -32'sd65536);
      send_item(clis_pkg::OP_APPEND, 32'sd0);
      send_item(clis_pkg::OP_APPEND, 32'sd65536);
      send_item(clis_pkg::OP_APPEND, 32'sd65536);
      // nothing at or above the key gives the last index; then low and near-zero queries
      send_item(clis_pkg::OP_QUERY, H_MAX);
      send_item(clis_pkg::OP_QUERY, H_MIN);
      send_item(clis_pkg::OP_QUERY, 32'sd60);
      send_item(clis_pkg::OP_QUERY, 32'sd66);
      send_item(clis_pkg::OP_QUERY, 32'sd67);
      // tie between neighbors goes to the later one
      send_item(clis_pkg::OP_QUERY, 32'sd32768);
      send_item(clis_pkg::OP_QUERY, 32'sd65536);
      send_item(clis_pkg::OP_APPEND, H_MAX);
      send_item(clis_pkg::OP_QUERY, H_MAX);
      // unsorted append
      send_item(clis_pkg::OP_APPEND, 32'sd100);
      send_item(clis_pkg::OP_QUERY, 32'sd50);
      send_item(clis_pkg::OP_CLEAR, H_MIN);
      send_item(clis_pkg::OP_QUERY, 32'sd5);
      drain_results();
      // zero tolerance: exact match only
      write_tolerance(32'h8000_0000);
      send_item(clis_pkg::OP_APPEND, 32'sd7);
      send_item(clis_pkg::OP_QUERY, 32'sd7);
      send_item(clis_pkg::OP_QUERY, 32'sd8);
      drain_results();
      // widest tolerance
      write_tolerance({1'b0, TOL_MAX});
      send_item(clis_pkg::OP_QUERY, H_MIN);
      send_item(clis_pkg::OP_QUERY, H_MAX);
      base_total = item_total;

      // random phases
      phase_no = 0;
      while (item_total < base_total + RAND_ITEMS) begin
         drain_results();
         case (phase_no)
            0: tol_pick = '0;
            1: tol_pick = TOL_MAX;
            default: begin
               case ($urandom_range(5))
                  0: tol_pick = '0;
                  1: tol_pick = clis_pkg::TOL_RESET;
                  2: tol_pick = TOL_MAX;
                  3: tol_pick = clis_pkg::TOL_W'($urandom_range(65536));
                  4: tol_pick = clis_pkg::TOL_W'($urandom);
                  default: tol_pick = clis_pkg::TOL_W'($urandom_range(1024));
               endcase
            end
         endcase
         write_tolerance({1'($urandom_range(1)), tol_pick});
         calm = (phase_no == 4);
         if (phase_no == 6) hold_go = 1'b1;
         run_phase(phase_no == 2);
         calm = 1'b0;
         phase_no++;
      end

      // wind down
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("closest_layer_index_search verification clean");
      end else begin
         $display("closest_layer_index_search verification failed");
      end
      $finish;
   end

endmodule
